/* rtl/i2cfm_pkg.sv */
// ============================================================================
// i2cfm_pkg
// Shared types and constants for the two-wire frame master sequencer.
// ============================================================================
package i2cfm_pkg;

    // Frame bytes
    localparam logic [7:0] ADDR_WRITE = 8'h50;
    localparam logic [7:0] ADDR_READ  = 8'h51;
    localparam logic [7:0] CMD_INIT   = 8'h00;
    localparam logic [7:0] CMD_RUN    = 8'h10;

    // Input beat actions
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_ARM  = 1'b1;

    // Pause lengths in prescaler ticks
    localparam logic [6:0] WAIT_START = 7'd3;
    localparam logic [6:0] WAIT_ADDR  = 7'd10;
    localparam logic [6:0] WAIT_WRITE = 7'd70;
    localparam logic [6:0] WAIT_READ  = 7'd100;

    // Configuration register indexes and reset values
    localparam logic CFG_INIT_HI = 1'b0;
    localparam logic CFG_INIT_LO = 1'b1;
    localparam logic [31:0] INIT_HI_RESET = 32'h1BD0_1400;
    localparam logic [31:0] INIT_LO_RESET = 32'h2100_1840;

    // Default length of the read frame in bytes (1 to 15)
    localparam int READ_BYTES_DEFAULT = 11;

    typedef struct packed {
        logic        action;
        logic        init_mode;
        logic [31:0] run_payload;
        logic        sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_enable;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] byte_data;
        logic [3:0] byte_index;
        logic       nack_abort;
    } out_item_t;

    typedef struct packed {
        logic        write_pending;
        logic        read_pending;
        logic [2:0]  frame_step;
        logic [4:0]  phase_tick;
        logic        data_phase;
        logic        load_pending;
        logic [7:0]  shift_byte;
        logic [3:0]  byte_counter;
        logic [6:0]  wait_limit;
        logic [7:0]  prescale_count;
        logic        init_latched;
        logic [31:0] run_latched;
        logic        scl;
        logic        sda;
        logic        sda_oe;
    } seq_state_t;

    localparam seq_state_t STATE_RESET = '{
        write_pending:  1'b0,
        read_pending:   1'b0,
        frame_step:     3'd0,
        phase_tick:     5'd0,
        data_phase:     1'b1,
        load_pending:   1'b0,
        shift_byte:     8'd0,
        byte_counter:   4'd0,
        wait_limit:     7'd0,
        prescale_count: 8'd0,
        init_latched:   1'b0,
        run_latched:    32'd0,
        scl:            1'b1,
        sda:            1'b1,
        sda_oe:         1'b1
    };

endpackage

/* rtl/i2cfm_step.sv */
// ============================================================================
// i2cfm_step
// Next-state and result logic for one beat: an arm command or a timer tick.
// ============================================================================
module i2cfm_step #(
    parameter int READ_BYTES = i2cfm_pkg::READ_BYTES_DEFAULT
) (
    input  i2cfm_pkg::seq_state_t state,
    input  i2cfm_pkg::in_item_t   item,
    input  logic [31:0]           init_hi,
    input  logic [31:0]           init_lo,
    output i2cfm_pkg::seq_state_t state_next,
    output i2cfm_pkg::out_item_t  result
);

    localparam logic [3:0] LAST_READ_IDX = 4'(READ_BYTES - 1);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_STOP,
        OP_WRITE,
        OP_READ
    } line_op_t;

    // Pick one byte of a word, first byte in the top bits
    function automatic logic [7:0] pick_byte(input logic [31:0] word, input logic [1:0] sel);
        logic [7:0] b;
        unique case (sel)
            2'd0:    b = word[31:24];
            2'd1:    b = word[23:16];
            2'd2:    b = word[15:8];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

    i2cfm_pkg::seq_state_t st;
    line_op_t   op;
    logic [7:0] wr_value;
    logic [7:0] payload;
    logic [3:0] write_last;
    logic       done;
    logic       nack;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic [3:0] rd_index;

    // Payload byte of the write frame
    always_comb
    begin
        if (state.init_latched)
        begin
            payload = pick_byte(state.byte_counter[2] ? init_lo : init_hi,
                                state.byte_counter[1:0]);
        end
        else
        begin
            payload = pick_byte(state.run_latched, state.byte_counter[1:0]);
        end
        write_last = state.init_latched ? 4'd7 : 4'd3;
    end

    // Select the line operation for the current frame step
    always_comb
    begin
        op       = OP_NONE;
        wr_value = i2cfm_pkg::ADDR_WRITE;
        if (state.write_pending)
        begin
            unique case (state.frame_step)
                3'd0: op = OP_START;
                3'd1: op = OP_WRITE;
                3'd2:
                begin
                    op       = OP_WRITE;
                    wr_value = state.init_latched ? i2cfm_pkg::CMD_INIT : i2cfm_pkg::CMD_RUN;
                end
                3'd3:
                begin
                    op       = OP_WRITE;
                    wr_value = payload;
                end
                3'd4: op = OP_STOP;
                default: op = OP_NONE;
            endcase
        end
        else if (state.read_pending)
        begin
            unique case (state.frame_step)
                3'd0: op = OP_START;
                3'd1: op = OP_WRITE;
                3'd2:
                begin
                    op       = OP_WRITE;
                    wr_value = i2cfm_pkg::CMD_RUN;
                end
                3'd3: op = OP_STOP;
                3'd4: op = OP_START;
                3'd5:
                begin
                    op       = OP_WRITE;
                    wr_value = i2cfm_pkg::ADDR_READ;
                end
                3'd6: op = OP_READ;
                default: op = OP_STOP;
            endcase
        end
    end

    // Advance the state by one beat
    always_comb
    begin
        st       = state;
        done     = 1'b0;
        nack     = 1'b0;
        rd_valid = 1'b0;
        rd_data  = 8'd0;
        rd_index = 4'd0;

        if (item.action == i2cfm_pkg::ACT_ARM)
        begin
            // Arm: latch the run payload and restart both frames
            st.init_latched  = item.init_mode;
            st.run_latched   = item.run_payload;
            st.data_phase    = 1'b1;
            st.frame_step    = 3'd0;
            st.phase_tick    = 5'd0;
            st.read_pending  = 1'b1;
            st.write_pending = 1'b1;
        end
        else
        begin
            st.prescale_count = state.prescale_count + 8'd1;
            if (st.prescale_count > {1'b0, state.wait_limit})
            begin
                st.wait_limit = 7'd0;
                st.phase_tick = state.phase_tick + 5'd1;

                // Run one half-step of the line operation
                unique case (op)
                    OP_START:
                    begin
                        st.sda_oe = 1'b1;
                        if (st.phase_tick == 5'd1)
                        begin
                            st.sda = 1'b1;
                            st.scl = 1'b1;
                        end
                        else if (st.phase_tick == 5'd2)
                        begin
                            st.sda = 1'b0;
                        end
                        else if (st.phase_tick == 5'd3)
                        begin
                            st.scl = 1'b0;
                            done   = 1'b1;
                        end
                    end
                    OP_STOP:
                    begin
                        st.sda_oe = 1'b1;
                        if (st.phase_tick == 5'd1)
                        begin
                            st.scl = 1'b0;
                            st.sda = 1'b0;
                        end
                        else if (st.phase_tick == 5'd2)
                        begin
                            st.scl = 1'b1;
                        end
                        else if (st.phase_tick == 5'd3)
                        begin
                            st.sda = 1'b1;
                            done   = 1'b1;
                        end
                    end
                    OP_WRITE:
                    begin
                        if (st.load_pending)
                        begin
                            st.shift_byte   = wr_value;
                            st.load_pending = 1'b0;
                        end
                        if (st.data_phase)
                        begin
                            if (st.phase_tick[0])
                            begin
                                st.scl    = 1'b0;
                                st.sda_oe = 1'b1;
                                st.sda    = st.shift_byte[7];
                            end
                            else
                            begin
                                st.scl = 1'b1;
                                if (st.phase_tick >= 5'd16)
                                begin
                                    st.data_phase = 1'b0;
                                    st.phase_tick = 5'd0;
                                end
                                else
                                begin
                                    st.shift_byte = {st.shift_byte[6:0], 1'b0};
                                end
                            end
                        end
                        else
                        begin
                            st.sda_oe = 1'b0;
                            if (st.phase_tick == 5'd1)
                            begin
                                st.scl = 1'b0;
                            end
                            else
                            begin
                                st.scl = 1'b1;
                                done   = 1'b1;
                                if (item.sda_in)
                                begin
                                    st.sda_oe = 1'b1;
                                    st.sda    = 1'b0;
                                    nack      = 1'b1;
                                end
                            end
                        end
                    end
                    OP_READ:
                    begin
                        if (st.data_phase)
                        begin
                            st.sda_oe = 1'b0;
                            if (st.phase_tick[0])
                            begin
                                st.scl = 1'b0;
                            end
                            else
                            begin
                                st.shift_byte[0] = item.sda_in;
                                if (st.phase_tick >= 5'd16)
                                begin
                                    st.phase_tick = 5'd0;
                                    st.data_phase = 1'b0;
                                end
                                else
                                begin
                                    st.shift_byte = {st.shift_byte[6:0], 1'b0};
                                end
                                st.scl = 1'b1;
                            end
                        end
                        else
                        begin
                            st.sda_oe = 1'b1;
                            if (st.phase_tick == 5'd1)
                            begin
                                st.scl = 1'b0;
                                // ACK every byte but the last
                                st.sda = (st.byte_counter < LAST_READ_IDX) ? 1'b0 : 1'b1;
                            end
                            else if (st.phase_tick == 5'd2)
                            begin
                                st.scl = 1'b1;
                                done   = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        // Nothing pending: hold the phase counter
                        st.phase_tick = state.phase_tick;
                    end
                endcase

                // Close the frame step once its operation is done
                if (done && state.write_pending)
                begin
                    unique case (state.frame_step)
                        3'd0:
                        begin
                            st.frame_step   = state.frame_step + 3'd1;
                            st.phase_tick   = 5'd0;
                            st.data_phase   = 1'b1;
                            st.load_pending = 1'b1;
                            st.wait_limit   = i2cfm_pkg::WAIT_START;
                        end
                        3'd1, 3'd2:
                        begin
                            st.frame_step   = state.frame_step + 3'd1;
                            st.phase_tick   = 5'd0;
                            st.data_phase   = 1'b1;
                            st.load_pending = 1'b1;
                            if (state.frame_step == 3'd2)
                            begin
                                st.byte_counter = 4'd0;
                            end
                        end
                        3'd3:
                        begin
                            st.byte_counter = state.byte_counter + 4'd1;
                            if (st.byte_counter > write_last)
                            begin
                                st.frame_step = state.frame_step + 3'd1;
                            end
                            st.load_pending = 1'b1;
                            st.phase_tick   = 5'd0;
                            st.data_phase   = 1'b1;
                        end
                        default:
                        begin
                            st.frame_step    = 3'd0;
                            st.phase_tick    = 5'd0;
                            st.data_phase    = 1'b1;
                            st.wait_limit    = i2cfm_pkg::WAIT_WRITE;
                            st.write_pending = 1'b0;
                        end
                    endcase
                end
                else if (done)
                begin
                    unique case (state.frame_step)
                        3'd6:
                        begin
                            rd_valid        = 1'b1;
                            rd_data         = st.shift_byte;
                            rd_index        = state.byte_counter;
                            st.byte_counter = state.byte_counter + 4'd1;
                            if (st.byte_counter > LAST_READ_IDX)
                            begin
                                st.frame_step = state.frame_step + 3'd1;
                            end
                            st.phase_tick = 5'd0;
                            st.data_phase = 1'b1;
                        end
                        3'd7:
                        begin
                            st.frame_step   = 3'd0;
                            st.phase_tick   = 5'd0;
                            st.data_phase   = 1'b1;
                            st.wait_limit   = i2cfm_pkg::WAIT_READ;
                            st.read_pending = 1'b0;
                        end
                        default:
                        begin
                            st.frame_step   = state.frame_step + 3'd1;
                            st.phase_tick   = 5'd0;
                            st.data_phase   = 1'b1;
                            st.load_pending = 1'b1;
                            if (state.frame_step == 3'd0 || state.frame_step == 3'd4)
                            begin
                                st.wait_limit = i2cfm_pkg::WAIT_ADDR;
                            end
                            else if (state.frame_step == 3'd3)
                            begin
                                st.wait_limit = i2cfm_pkg::WAIT_READ;
                            end
                            if (state.frame_step == 3'd5)
                            begin
                                st.byte_counter = 4'd0;
                            end
                        end
                    endcase
                end

                st.prescale_count = 8'd0;

                // Drop both frames and release the lines on a slave NACK
                if (nack)
                begin
                    st.write_pending = 1'b0;
                    st.read_pending  = 1'b0;
                    st.sda           = 1'b1;
                    st.scl           = 1'b1;
                end
            end
        end
    end

    // Drive the result beat
    always_comb
    begin
        state_next        = st;
        result.scl_level  = st.scl;
        result.sda_level  = st.sda;
        result.sda_enable = st.sda_oe;
        result.busy_res   = st.write_pending | st.read_pending;
        result.byte_valid = rd_valid;
        result.byte_data  = rd_data;
        result.byte_index = rd_index;
        result.nack_abort = nack;
    end

endmodule

/* rtl/i2c_frame_master_sequencer_core.sv */
// ============================================================================
// i2c_frame_master_sequencer_core
// Tick-driven two-wire frame master: a write frame, then a read frame.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready/in_data): each beat is either a timer
//   tick (action 0, carrying the sampled data line) or an arm command
//   (action 1, carrying the frame mode and the four run bytes).
//   Output channel (out_valid/out_ready/out_data): exactly one result beat
//   per input beat, in order: line levels, busy flag, any completed read
//   byte and the NACK abort flag.
//   Configuration: cfg_wr_en writes cfg_data into the init payload register
//   chosen by cfg_index in the same cycle; write only while idle.
//   Result timing: the result of a beat is on out_data in the cycle after the
//   beat is taken. Throughput: one beat per cycle while out_ready is high, set by the single output register.
//   Stall: while a result waits and out_ready is low, in_ready is low; the
//   next beat is taken in the cycle the waiting result leaves.
//   Reset: both frames idle, lines released high with the data driver on,
//   init payload registers at their defaults, output register empty.
// ============================================================================
module i2c_frame_master_sequencer_core #(
    parameter int READ_BYTES = i2cfm_pkg::READ_BYTES_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  i2cfm_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output i2cfm_pkg::out_item_t out_data,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);

    i2cfm_pkg::seq_state_t state_reg;
    i2cfm_pkg::seq_state_t state_next;
    i2cfm_pkg::out_item_t  result;
    i2cfm_pkg::out_item_t  out_data_reg;
    logic                  out_valid_reg;
    logic [31:0]           init_hi_reg;
    logic [31:0]           init_lo_reg;
    logic                  in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    i2cfm_step #(
        .READ_BYTES (READ_BYTES)
    ) u_step (
        .state      (state_reg),
        .item       (in_data),
        .init_hi    (init_hi_reg),
        .init_lo    (init_lo_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Hold the sequencer state; advance on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2cfm_pkg::STATE_RESET;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Init payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_hi_reg <= i2cfm_pkg::INIT_HI_RESET;
            init_lo_reg <= i2cfm_pkg::INIT_LO_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                i2cfm_pkg::CFG_INIT_HI: init_hi_reg <= cfg_data;
                i2cfm_pkg::CFG_INIT_LO: init_lo_reg <= cfg_data;
                default:                init_hi_reg <= init_hi_reg;
            endcase
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A taken beat always produces a result beat next cycle
    a_beat_to_result : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted beat produced no result");

    // A NACK abort leaves both frames dropped and both lines high
    a_nack_release : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.nack_abort) |->
        (!out_data_reg.busy_res && out_data_reg.scl_level && out_data_reg.sda_level
         && !out_data_reg.byte_valid))
        else $error("NACK abort did not release the bus");

    // A read byte only completes inside a busy read frame, within its length
    a_read_byte_range : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.byte_valid) |->
        (out_data_reg.busy_res && out_data_reg.byte_index <= 4'(READ_BYTES - 1)))
        else $error("read byte outside read frame");

endmodule
